@@ design/yrgb_pkg.sv @@
// Shared types, constants, chroma lookup tables and helper functions for the YCbCr to RGB unit.
package yrgb_pkg;

    localparam int PIXEL_WORD_BITS = 16;
    localparam int SAMPLE_BITS     = 8;
    localparam int TERM_BITS       = 9;
    localparam int SUM_BITS        = 10;
    localparam int SHIFT_BITS      = 4;
    localparam int COUNT_BITS      = 5;
    localparam int NUM_CHANNELS    = 3;
    localparam int NUM_LANES       = 4;
    localparam int ROM_DEPTH       = 256;
    localparam int CHROMA_OFFSET   = 128;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [PIXEL_WORD_BITS-1:0] RED_MASK_RESET   = 16'hF800;
    localparam logic [PIXEL_WORD_BITS-1:0] GREEN_MASK_RESET = 16'h07E0;
    localparam logic [PIXEL_WORD_BITS-1:0] BLUE_MASK_RESET  = 16'h001F;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RED   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GREEN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLUE  = 2'd2;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam int TERM_CRR = 0;
    localparam int TERM_CRG = 1;
    localparam int TERM_CBG = 2;
    localparam int TERM_CBB = 3;

    localparam int CRR_NUM = 419;
    localparam int CRR_DEN = 299;
    localparam int CRG_NUM = 299;
    localparam int CRG_DEN = 419;
    localparam int CBG_NUM = 114;
    localparam int CBG_DEN = 331;
    localparam int CBB_NUM = 587;
    localparam int CBB_DEN = 331;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] luma_top_left;
        logic [SAMPLE_BITS-1:0] luma_top_right;
        logic [SAMPLE_BITS-1:0] luma_bottom_left;
        logic [SAMPLE_BITS-1:0] luma_bottom_right;
        logic [SAMPLE_BITS-1:0] chroma_red;
        logic [SAMPLE_BITS-1:0] chroma_blue;
    } block_t;

    typedef struct packed {
        logic [PIXEL_WORD_BITS-1:0] pixel_top_left;
        logic [PIXEL_WORD_BITS-1:0] pixel_top_right;
        logic [PIXEL_WORD_BITS-1:0] pixel_bottom_left;
        logic [PIXEL_WORD_BITS-1:0] pixel_bottom_right;
    } pixels_t;

    typedef struct packed {
        logic [SHIFT_BITS-1:0] rsh;
        logic [SHIFT_BITS-1:0] pos;
    } field_t;

    typedef field_t [NUM_CHANNELS-1:0] field_set_t;

    typedef struct packed {
        logic signed [TERM_BITS-1:0] crr;
        logic signed [TERM_BITS-1:0] cg;
        logic signed [TERM_BITS-1:0] cbb;
    } chroma_t;

    typedef logic [ROM_DEPTH-1:0][TERM_BITS-1:0] term_rom_t;

    function automatic logic [TERM_BITS-1:0] term_value(input int sel, input int code);
        int d;
        int mag;
        int q;
        int v;
        d   = code - CHROMA_OFFSET;
        mag = (d < 0) ? -d : d;
        case (sel)
            TERM_CRR: q = (CRR_NUM * mag) / CRR_DEN;
            TERM_CRG: q = (CRG_NUM * mag) / CRG_DEN;
            TERM_CBG: q = (CBG_NUM * mag) / CBG_DEN;
            TERM_CBB: q = (CBB_NUM * mag) / CBB_DEN;
            default:  q = 0;
        endcase
        v = (d < 0) ? -q : q;
        if (sel == TERM_CRG || sel == TERM_CBG) begin
            v = -v;
        end
        return TERM_BITS'(v);
    endfunction

    function automatic term_rom_t build_term_rom(input int sel);
        term_rom_t rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = term_value(sel, i);
        end
        return rom;
    endfunction

    localparam term_rom_t CRR_ROM = build_term_rom(TERM_CRR);
    localparam term_rom_t CRG_ROM = build_term_rom(TERM_CRG);
    localparam term_rom_t CBG_ROM = build_term_rom(TERM_CBG);
    localparam term_rom_t CBB_ROM = build_term_rom(TERM_CBB);

    function automatic field_t field_decode(input logic [PIXEL_WORD_BITS-1:0] mask);
        logic [COUNT_BITS-1:0] n;
        logic [SHIFT_BITS-1:0] pos;
        field_t f;
        n   = '0;
        pos = '0;
        for (int i = 0; i < PIXEL_WORD_BITS; i++) begin
            n = n + COUNT_BITS'(mask[i]);
        end
        for (int i = PIXEL_WORD_BITS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                pos = SHIFT_BITS'(i);
            end
        end
        if (n > COUNT_BITS'(SAMPLE_BITS)) begin
            n = COUNT_BITS'(SAMPLE_BITS);
        end
        f.rsh = SHIFT_BITS'(COUNT_BITS'(SAMPLE_BITS) - n);
        f.pos = pos;
        return f;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] clamp_channel(input logic signed [SUM_BITS-1:0] v);
        if (v < 0) begin
            return '0;
        end
        if (v > SUM_BITS'(255)) begin
            return '1;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [PIXEL_WORD_BITS-1:0] place_channel(input logic [SAMPLE_BITS-1:0] ch,
                                                                 input field_t f);
        logic [PIXEL_WORD_BITS-1:0] w;
        w = PIXEL_WORD_BITS'(ch >> f.rsh);
        return w << f.pos;
    endfunction

endpackage

@@ design/yrgb_field.sv @@
// Field mask register port that keeps each channel's decoded shift and position.
module yrgb_field
    import yrgb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [PIXEL_WORD_BITS-1:0] cfg_data,
    output field_set_t                 fields
);

    field_set_t fields_reg;
    field_set_t fields_next;
    field_t     decoded;

    always_comb
    begin
        decoded     = field_decode(cfg_data);
        fields_next = fields_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RED:   fields_next[CH_RED]   = decoded;
                CFG_GREEN: fields_next[CH_GREEN] = decoded;
                CFG_BLUE:  fields_next[CH_BLUE]  = decoded;
                default:   fields_next = fields_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_reg[CH_RED]   <= field_decode(RED_MASK_RESET);
            fields_reg[CH_GREEN] <= field_decode(GREEN_MASK_RESET);
            fields_reg[CH_BLUE]  <= field_decode(BLUE_MASK_RESET);
        end
        else
        begin
            fields_reg <= fields_next;
        end
    end

    assign fields = fields_reg;

endmodule

@@ design/yrgb_chroma.sv @@
// Chroma stage: table lookup of the four chroma terms, registered with the luma samples.
module yrgb_chroma
    import yrgb_pkg::*;
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  block_t                               block,
    output logic                                 valid,
    output chroma_t                              terms,
    output logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] luma
);

    logic                                  valid_reg;
    chroma_t                               terms_reg;
    chroma_t                               terms_next;
    logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] luma_reg;
    logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] luma_next;
    logic signed [TERM_BITS-1:0]           crg;
    logic signed [TERM_BITS-1:0]           cbg;

    always_comb
    begin
        crg              = CRG_ROM[block.chroma_red];
        cbg              = CBG_ROM[block.chroma_blue];
        terms_next.crr   = CRR_ROM[block.chroma_red];
        terms_next.cbb   = CBB_ROM[block.chroma_blue];
        terms_next.cg    = TERM_BITS'(SUM_BITS'(crg) + SUM_BITS'(cbg));
        luma_next[0]     = block.luma_top_left;
        luma_next[1]     = block.luma_top_right;
        luma_next[2]     = block.luma_bottom_left;
        luma_next[3]     = block.luma_bottom_right;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            terms_reg <= terms_next;
            luma_reg  <= luma_next;
        end
    end

    assign valid = valid_reg;
    assign terms = terms_reg;
    assign luma  = luma_reg;

endmodule

@@ design/yrgb_lane.sv @@
// One pixel lane: adds the chroma terms to luma, saturates and places the three channels.
module yrgb_lane
    import yrgb_pkg::*;
(
    input  logic [SAMPLE_BITS-1:0]     luma,
    input  chroma_t                    terms,
    input  field_set_t                 fields,
    output logic [PIXEL_WORD_BITS-1:0] word
);

    logic signed [SUM_BITS-1:0] y;
    logic [SAMPLE_BITS-1:0]     r;
    logic [SAMPLE_BITS-1:0]     g;
    logic [SAMPLE_BITS-1:0]     b;

    always_comb
    begin
        y    = $signed({2'b00, luma});
        r    = clamp_channel(y + SUM_BITS'(terms.crr));
        g    = clamp_channel(y + SUM_BITS'(terms.cg));
        b    = clamp_channel(y + SUM_BITS'(terms.cbb));
        word = place_channel(r, fields[CH_RED]) |
               place_channel(g, fields[CH_GREEN]) |
               place_channel(b, fields[CH_BLUE]);
    end

endmodule

@@ design/ycbcr_block_to_rgb_packed_unit.sv @@
// Top level of the 2x2 YCbCr block to packed RGB converter.
// The unit takes one 2x2 block on every clock cycle: busy is always low, so a block is
// accepted at any edge where start is high. Its four packed pixels appear on pixels with
// done high, for one cycle only; the receiver must take them then.
// A block passes the chroma table stage and then the stage where the four pixel lanes add,
// saturate, place the fields and register the merged result. Field masks written on the
// configuration port apply to the block accepted at the same edge as the write and to
// every later block.
module ycbcr_block_to_rgb_packed_unit
    import yrgb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  block_t                     block,
    output logic                       done,
    output pixels_t                    pixels,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [PIXEL_WORD_BITS-1:0] cfg_data
);

    field_set_t                                fields;
    logic                                      accept;
    logic                                      stage_valid;
    chroma_t                                   terms;
    logic [NUM_LANES-1:0][SAMPLE_BITS-1:0]     luma;
    logic [NUM_LANES-1:0][PIXEL_WORD_BITS-1:0] words;
    logic                                      done_reg;
    pixels_t                                   pixels_reg;
    pixels_t                                   pixels_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    yrgb_field u_field (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fields    (fields)
    );

    yrgb_chroma u_chroma (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .block  (block),
        .valid  (stage_valid),
        .terms  (terms),
        .luma   (luma)
    );

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        yrgb_lane u_lane (
            .luma   (luma[k]),
            .terms  (terms),
            .fields (fields),
            .word   (words[k])
        );
    end

    always_comb
    begin
        pixels_next.pixel_top_left     = words[0];
        pixels_next.pixel_top_right    = words[1];
        pixels_next.pixel_bottom_left  = words[2];
        pixels_next.pixel_bottom_right = words[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid)
        begin
            pixels_reg <= pixels_next;
        end
    end

    assign done   = done_reg;
    assign pixels = pixels_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted block produced no result two cycles later");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result strobe without an accepted block");

    a_stage_matches_done: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid |=> done)
        else $error("lane stage result was not presented");

endmodule
